// ===== rtl/blg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blg_pkg: shared types, constants and control program of the battery gauge
// Holds the segment table for the charge curve and the microcode of the
// sequencer that steps the datapath for each item.
// ----------------------------------------------------------------------------
package blg_pkg;

	// default sizes
	localparam int RING_DEPTH_DEF = 8;
	localparam int ADC_BITS_DEF   = 10;

	// field widths
	localparam int SCALE_W    = 20;
	localparam int PCT_W      = 7;
	localparam int MV_W       = 14;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	// curve arithmetic widths
	localparam int SPAN_W     = 10;   // largest segment span is 800 mV
	localparam int DROP_W     = 5;    // largest percent drop is 23
	localparam int NPROD_W    = SPAN_W + DROP_W;
	localparam int NUM_W      = 13;   // (hi - mv) * drop stays below 8192
	// span reciprocal is 2^RECIP_SH / span rounded up, exact for numerators below 2^NUM_W
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 23;
	localparam int QPROD_W    = NUM_W + RECIP_W;
	localparam int NUM_SEG    = 5;
	localparam int SEG_IDX_W  = 3;
	localparam int STEP_W     = 4;

	// register reset values; scale is 4.2 * 20 / 12.9 in Q16, rounded
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(426746);
	localparam logic [PCT_W-1:0]   WARN_RESET  = PCT_W'(20);

	localparam logic [MV_W-1:0]  MV_MAX    = MV_W'(16383);
	localparam logic [MV_W-1:0]  MV_TOP    = MV_W'(4200);
	localparam logic [MV_W-1:0]  MV_BOTTOM = MV_W'(2600);
	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
	localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LOW_WARNING   = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_RING_UPD,
		OP_AVG,
		OP_MUL,
		OP_SEG,
		OP_PCT_DIV,
		OP_PCT_SUB,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_GOTO,
		C_WAIT_IN,
		C_SKIP_SPECIAL,
		C_WAIT_OUT
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic special;
	} seq_stat_t;

	function automatic logic [MV_W-1:0] seg_hi_mv(input logic [SEG_IDX_W-1:0] k);
		logic [MV_W-1:0] r;
		unique case (k)
			3'd0:    r = MV_W'(4200);
			3'd1:    r = MV_W'(3870);
			3'd2:    r = MV_W'(3750);
			3'd3:    r = MV_W'(3680);
			3'd4:    r = MV_W'(3400);
			default: r = MV_W'(3400);
		endcase
		return r;
	endfunction

	function automatic logic [MV_W-1:0] seg_lo_mv(input logic [SEG_IDX_W-1:0] k);
		logic [MV_W-1:0] r;
		unique case (k)
			3'd0:    r = MV_W'(3870);
			3'd1:    r = MV_W'(3750);
			3'd2:    r = MV_W'(3680);
			3'd3:    r = MV_W'(3400);
			3'd4:    r = MV_W'(2600);
			default: r = MV_W'(2600);
		endcase
		return r;
	endfunction

	function automatic logic [PCT_W-1:0] seg_hi_pct(input logic [SEG_IDX_W-1:0] k);
		logic [PCT_W-1:0] r;
		unique case (k)
			3'd0:    r = PCT_W'(100);
			3'd1:    r = PCT_W'(77);
			3'd2:    r = PCT_W'(54);
			3'd3:    r = PCT_W'(31);
			3'd4:    r = PCT_W'(8);
			default: r = PCT_W'(8);
		endcase
		return r;
	endfunction

	function automatic logic [DROP_W-1:0] seg_drop(input logic [SEG_IDX_W-1:0] k);
		logic [DROP_W-1:0] r;
		unique case (k)
			3'd0:    r = DROP_W'(23);
			3'd1:    r = DROP_W'(23);
			3'd2:    r = DROP_W'(23);
			3'd3:    r = DROP_W'(23);
			3'd4:    r = DROP_W'(8);
			default: r = DROP_W'(8);
		endcase
		return r;
	endfunction

	// spans 330, 120, 70, 280 and 800 mV
	function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_IDX_W-1:0] k);
		logic [RECIP_W-1:0] r;
		unique case (k)
			3'd0:    r = RECIP_W'(25421);
			3'd1:    r = RECIP_W'(69906);
			3'd2:    r = RECIP_W'(119838);
			3'd3:    r = RECIP_W'(29960);
			3'd4:    r = RECIP_W'(10486);
			default: r = RECIP_W'(10486);
		endcase
		return r;
	endfunction

	// control program, one word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		unique case (step)
			4'd0:    w = '{op: OP_WAIT_IN,  cond: C_WAIT_IN,      target: STEP_W'(0)};
			4'd1:    w = '{op: OP_RING_UPD, cond: C_NEXT,         target: STEP_W'(0)};
			4'd2:    w = '{op: OP_AVG,      cond: C_NEXT,         target: STEP_W'(0)};
			4'd3:    w = '{op: OP_MUL,      cond: C_NEXT,         target: STEP_W'(0)};
			4'd4:    w = '{op: OP_SEG,      cond: C_SKIP_SPECIAL, target: STEP_W'(7)};
			4'd5:    w = '{op: OP_PCT_DIV,  cond: C_NEXT,         target: STEP_W'(0)};
			4'd6:    w = '{op: OP_PCT_SUB,  cond: C_NEXT,         target: STEP_W'(0)};
			4'd7:    w = '{op: OP_DONE,     cond: C_WAIT_OUT,     target: STEP_W'(0)};
			default: w = '{op: OP_NOP,      cond: C_GOTO,         target: STEP_W'(0)};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/blg_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blg_sequencer: step counter and control store
// Fetches one control word per step and picks the next step from the
// word's jump condition and the datapath status.
// ----------------------------------------------------------------------------
module blg_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire blg_pkg::seq_stat_t stat,
	output blg_pkg::ctrl_t          ctrl
);

	logic [blg_pkg::STEP_W-1:0] step_q;
	logic [blg_pkg::STEP_W-1:0] step_d;
	logic [blg_pkg::STEP_W-1:0] step_inc;

	assign ctrl     = blg_pkg::ucode(step_q);
	assign step_inc = step_q + blg_pkg::STEP_W'(1);

	always_comb begin
		unique case (ctrl.cond)
			blg_pkg::C_NEXT:         step_d = step_inc;
			blg_pkg::C_GOTO:         step_d = ctrl.target;
			blg_pkg::C_WAIT_IN:      step_d = stat.in_valid ? step_inc : step_q;
			blg_pkg::C_SKIP_SPECIAL: step_d = stat.special ? ctrl.target : step_inc;
			blg_pkg::C_WAIT_OUT:     step_d = stat.out_free ? ctrl.target : step_q;
			default:                 step_d = blg_pkg::STEP_W'(0);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/blg_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blg_ring: sample ring with running sum
// Stores the last RING_DEPTH samples and keeps their sum up to date by
// adding the new sample and taking off the one it overwrites.
// ----------------------------------------------------------------------------
module blg_ring #(
	parameter int RING_DEPTH = blg_pkg::RING_DEPTH_DEF,
	parameter int ADC_BITS   = blg_pkg::ADC_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire blg_pkg::ctrl_t                          ctrl,
	input  wire logic                                    accept,
	input  wire logic [ADC_BITS-1:0]                     sample,
	output logic [ADC_BITS+$clog2(RING_DEPTH)-1:0]       sum,
	output logic                                         filled
);

	localparam int SUM_W = ADC_BITS + $clog2(RING_DEPTH);
	localparam int WP_W  = $clog2(RING_DEPTH);

	logic [ADC_BITS-1:0] mem [RING_DEPTH];
	logic [ADC_BITS-1:0] rd_q;
	logic [ADC_BITS-1:0] sample_q;
	logic [ADC_BITS-1:0] old_val;
	logic [WP_W-1:0]     wp_q;
	logic [SUM_W-1:0]    sum_q;
	logic                filled_q;
	logic                upd;

	assign upd    = (ctrl.op == blg_pkg::OP_RING_UPD);
	// entries past the write position are unwritten until the first wrap
	assign old_val = filled_q ? rd_q : '0;
	assign sum    = sum_q;
	assign filled = filled_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[wp_q];
		if (upd) begin
			mem[wp_q] <= sample_q;
		end
		if (accept) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			sum_q    <= '0;
			filled_q <= 1'b0;
		end else if (upd) begin
			sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(old_val);
			if (wp_q == WP_W'(RING_DEPTH - 1)) begin
				wp_q     <= '0;
				filled_q <= 1'b1;
			end else begin
				wp_q <= wp_q + WP_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/blg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blg_datapath: averager, scaler and charge curve
// Reciprocal multiplications make the average and the segment
// interpolation; a multiplier turns the average into millivolts.
// ----------------------------------------------------------------------------
module blg_datapath #(
	parameter int RING_DEPTH = blg_pkg::RING_DEPTH_DEF,
	parameter int ADC_BITS   = blg_pkg::ADC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire blg_pkg::ctrl_t                         ctrl,
	input  wire logic [ADC_BITS+$clog2(RING_DEPTH)-1:0] sum,
	input  wire logic                                   filled,
	input  wire logic [blg_pkg::SCALE_W-1:0]            scale,
	output logic                                        special,
	output logic [blg_pkg::PCT_W-1:0]                   pct,
	output logic [blg_pkg::MV_W-1:0]                    mv
);

	localparam int     SUM_W   = ADC_BITS + $clog2(RING_DEPTH);
	// sum / RING_DEPTH as (sum * AVG_M) >> AVG_SH, exact for every sum below 2^SUM_W
	localparam int     AVG_SH  = SUM_W + $clog2(RING_DEPTH);
	localparam longint AVG_M   = ((longint'(1) << AVG_SH) + longint'(RING_DEPTH) - 1)
		/ longint'(RING_DEPTH);
	localparam int     AVG_P_W = 2 * SUM_W + 1;
	localparam int     PROD_W  = ADC_BITS + blg_pkg::SCALE_W;
	localparam int     MVF_W   = PROD_W - 16;
	localparam int     MVC_W   = (MVF_W > blg_pkg::MV_W) ? MVF_W : blg_pkg::MV_W;

	// averaging
	logic [AVG_P_W-1:0]  avg_prod;
	logic [ADC_BITS-1:0] avg_q;

	// curve
	logic [blg_pkg::MV_W-1:0]      mv_q;
	logic [blg_pkg::PCT_W-1:0]     pct_q;
	logic [blg_pkg::PCT_W-1:0]     ohi_q;
	logic [blg_pkg::PCT_W-1:0]     quo_q;
	logic [blg_pkg::NUM_W-1:0]     numer_q;
	logic [blg_pkg::RECIP_W-1:0]   recip_q;
	logic [blg_pkg::QPROD_W-1:0]   quo_prod;
	logic [blg_pkg::SEG_IDX_W-1:0] seg_idx;
	logic [blg_pkg::SPAN_W-1:0]    diff;
	logic [blg_pkg::NPROD_W-1:0]   nprod;
	logic [blg_pkg::PCT_W-1:0]     special_pct;

	// scaling
	logic [PROD_W-1:0]        prod;
	logic [MVC_W-1:0]         mvc;
	logic [blg_pkg::MV_W-1:0] mv_sat;

	assign avg_prod = AVG_P_W'(sum) * AVG_P_W'(AVG_M);

	assign prod   = PROD_W'(avg_q) * PROD_W'(scale);
	assign mvc    = MVC_W'(prod[PROD_W-1:16]);
	assign mv_sat = (mvc > MVC_W'(blg_pkg::MV_MAX)) ? blg_pkg::MV_MAX
		: mvc[blg_pkg::MV_W-1:0];

	assign special = !filled || (mv_q > blg_pkg::MV_TOP) || (mv_q <= blg_pkg::MV_BOTTOM);
	assign special_pct = (filled && (mv_q <= blg_pkg::MV_BOTTOM)) ? blg_pkg::PCT_EMPTY
		: blg_pkg::PCT_FULL;

	// first segment whose lower end lies below the voltage
	always_comb begin
		seg_idx = '0;
		for (int k = blg_pkg::NUM_SEG - 1; k >= 0; k--) begin
			if (mv_q > blg_pkg::seg_lo_mv(blg_pkg::SEG_IDX_W'(k))) begin
				seg_idx = blg_pkg::SEG_IDX_W'(k);
			end
		end
	end

	assign diff  = blg_pkg::SPAN_W'(blg_pkg::seg_hi_mv(seg_idx) - mv_q);
	assign nprod = blg_pkg::NPROD_W'(diff) * blg_pkg::NPROD_W'(blg_pkg::seg_drop(seg_idx));

	assign quo_prod = blg_pkg::QPROD_W'(numer_q) * blg_pkg::QPROD_W'(recip_q);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			blg_pkg::OP_AVG: begin
				avg_q <= avg_prod[AVG_SH +: ADC_BITS];
			end
			blg_pkg::OP_MUL: begin
				mv_q <= mv_sat;
			end
			blg_pkg::OP_SEG: begin
				pct_q   <= special_pct;
				ohi_q   <= blg_pkg::seg_hi_pct(seg_idx);
				numer_q <= blg_pkg::NUM_W'(nprod);
				recip_q <= blg_pkg::seg_recip(seg_idx);
			end
			blg_pkg::OP_PCT_DIV: begin
				quo_q <= quo_prod[blg_pkg::RECIP_SH +: blg_pkg::PCT_W];
			end
			blg_pkg::OP_PCT_SUB: begin
				pct_q <= ohi_q - quo_q;
			end
			default: begin
			end
		endcase
	end

	assign pct = pct_q;
	assign mv  = mv_q;

endmodule
`default_nettype wire

// ===== rtl/battery_level_gauge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_level_gauge: battery charge estimator
// Averages ADC samples over a ring, scales to millivolts and maps the
// voltage to a charge percent over a piecewise-linear curve.
// ----------------------------------------------------------------------------
// flow: ring update, average, multiply and segment steps, then divide and subtract;
//   the last two are skipped when the curve is skipped (ring not yet full, or
//   voltage outside the curve). One item at a time, stepped by the eight-step
//   control program; a result not yet taken holds the last step
// reset: ring sum, write position, fill flag and step counter clear at once;
//   the registers return to their reset values, no clearing pass
// ----------------------------------------------------------------------------
module battery_level_gauge #(
	parameter int RING_DEPTH = blg_pkg::RING_DEPTH_DEF,
	parameter int ADC_BITS   = blg_pkg::ADC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [ADC_BITS-1:0]              adc_sample,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [blg_pkg::PCT_W-1:0]             level_percent,
	output logic                                  low_battery,
	output logic                                  average_ready,
	output logic [blg_pkg::MV_W-1:0]              battery_millivolts,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [blg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [blg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SUM_W = ADC_BITS + $clog2(RING_DEPTH);

	blg_pkg::ctrl_t     ctrl;
	blg_pkg::seq_stat_t stat;

	logic [blg_pkg::SCALE_W-1:0] scale_q;
	logic [blg_pkg::PCT_W-1:0]   warn_q;
	logic [SUM_W-1:0]            ring_sum;
	logic                        ring_filled;
	logic                        special;
	logic [blg_pkg::PCT_W-1:0]   pct;
	logic [blg_pkg::MV_W-1:0]    mv;
	logic                        accept;
	logic                        out_free;
	logic                        load_out;

	logic                        out_valid_q;
	logic [blg_pkg::PCT_W-1:0]   pct_q;
	logic                        low_q;
	logic                        ready_q;
	logic [blg_pkg::MV_W-1:0]    mv_q;

	assign in_ready  = (ctrl.op == blg_pkg::OP_WAIT_IN);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (ctrl.op == blg_pkg::OP_DONE) && out_free;
	assign cfg_ready = 1'b1;

	assign stat = '{in_valid: in_valid, out_free: out_free, special: special};

	blg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	blg_ring #(
		.RING_DEPTH (RING_DEPTH),
		.ADC_BITS   (ADC_BITS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.accept (accept),
		.sample (adc_sample),
		.sum    (ring_sum),
		.filled (ring_filled)
	);

	blg_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.ADC_BITS   (ADC_BITS)
	) u_dp (
		.clk      (clk),
		.ctrl     (ctrl),
		.sum      (ring_sum),
		.filled   (ring_filled),
		.scale    (scale_q),
		.special  (special),
		.pct      (pct),
		.mv       (mv)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= blg_pkg::SCALE_RESET;
			warn_q  <= blg_pkg::WARN_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == blg_pkg::REG_VOLTAGE_SCALE) begin
				scale_q <= blg_pkg::SCALE_W'(cfg_data);
			end else if (cfg_index == blg_pkg::REG_LOW_WARNING) begin
				warn_q <= cfg_data[blg_pkg::PCT_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pct_q   <= pct;
			low_q   <= (pct < warn_q);
			ready_q <= ring_filled;
			mv_q    <= mv;
		end
	end

	assign out_valid          = out_valid_q;
	assign level_percent      = pct_q;
	assign low_battery        = low_q;
	assign average_ready      = ready_q;
	assign battery_millivolts = mv_q;

	// one item in flight: no second item right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item taken while previous one still at work");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pct_q <= blg_pkg::PCT_FULL))
		else $error("percent out of range");

	a_full_before_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ready_q) |-> (pct_q == blg_pkg::PCT_FULL))
		else $error("percent not full before ring filled");

	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ring_filled |=> ring_filled)
		else $error("ring fill flag dropped");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for battery_level_gauge
// Drives ADC samples and register writes over valid/ready channels with
// random idle gaps, mirrors the averaging ring, millivolt scaling and charge
// curve in a local model, and compares every reading with the model.
// ----------------------------------------------------------------------------
module testbench;
	import blg_pkg::*;

	localparam int ADC_W          = ADC_BITS_DEF;
	localparam int RING_SLOTS     = RING_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int SWEEP_PHASES   = 15;
	// index that maps to no register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

	typedef struct packed {
		logic [PCT_W-1:0] level_percent;
		logic             low_battery;
		logic             average_ready;
		logic [MV_W-1:0]  battery_millivolts;
	} gauge_reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ADC_W-1:0]      adc_sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PCT_W-1:0]      level_percent;
	logic                  low_battery;
	logic                  average_ready;
	logic [MV_W-1:0]       battery_millivolts;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// local copy of the gauge state and registers
	logic [ADC_W-1:0]   ring_mirror [RING_SLOTS];
	logic [2:0]         ring_wr_ptr;
	logic               ring_full;
	logic [SCALE_W-1:0] scale_mirror;
	logic [PCT_W-1:0]   warn_mirror;

	gauge_reading_t pending_readings [$];
	int             mismatch_count = 0;
	int             idle_cycles = 0;
	int             send_gap = 0;
	bit             send_fast = 1'b0;

	battery_level_gauge u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.adc_sample         (adc_sample),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level_percent      (level_percent),
		.low_battery        (low_battery),
		.average_ready      (average_ready),
		.battery_millivolts (battery_millivolts),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// knee points of the charge curve, top to bottom
	function automatic int knee_mv(input int k);
		case (k)
			0:       return 4200;
			1:       return 3870;
			2:       return 3750;
			3:       return 3680;
			4:       return 3400;
			default: return 2600;
		endcase
	endfunction

	function automatic int knee_pct(input int k);
		case (k)
			0:       return 100;
			1:       return 77;
			2:       return 54;
			3:       return 31;
			4:       return 8;
			default: return 0;
		endcase
	endfunction

	function automatic logic [PCT_W-1:0] curve_percent(input int mv);
		int drop;
		int span;
		if (mv > knee_mv(0))
			return PCT_FULL;
		for (int k = 1; k < 6; k++) begin
			if (mv > knee_mv(k)) begin
				drop = knee_pct(k - 1) - knee_pct(k);
				span = knee_mv(k - 1) - knee_mv(k);
				return PCT_W'(knee_pct(k - 1) - ((knee_mv(k - 1) - mv) * drop) / span);
			end
		end
		return PCT_EMPTY;
	endfunction

	// advance the local ring with one accepted sample and queue the reading
	task automatic predict_reading(input logic [ADC_W-1:0] sample);
		logic [12:0]    ring_sum;
		logic [29:0]    scaled;
		logic [29:0]    mv_raw;
		gauge_reading_t want;
		ring_mirror[ring_wr_ptr] = sample;
		ring_wr_ptr = ring_wr_ptr + 3'd1;
		if (ring_wr_ptr == 3'd0)
			ring_full = 1'b1;
		ring_sum = '0;
		foreach (ring_mirror[k])
			ring_sum = ring_sum + 13'(ring_mirror[k]);
		scaled = 30'(ring_sum >> 3) * 30'(scale_mirror);
		mv_raw = scaled >> 16;
		want.battery_millivolts = (mv_raw > 30'(MV_MAX)) ? MV_MAX : mv_raw[MV_W-1:0];
		want.average_ready = ring_full;
		want.level_percent = ring_full ? curve_percent(int'(want.battery_millivolts)) : PCT_FULL;
		want.low_battery = (want.level_percent < warn_mirror);
		pending_readings.push_back(want);
	endtask

	task automatic check_reading();
		gauge_reading_t want;
		gauge_reading_t got;
		got.level_percent = level_percent;
		got.low_battery = low_battery;
		got.average_ready = average_ready;
		got.battery_millivolts = battery_millivolts;
		if (pending_readings.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: reading with none pending: pct=%0d low=%0b ready=%0b mv=%0d",
					$realtime, got.level_percent, got.low_battery, got.average_ready,
					got.battery_millivolts);
		end else begin
			want = pending_readings.pop_front();
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: mismatch exp pct=%0d low=%0b ready=%0b mv=%0d, got pct=%0d low=%0b ready=%0b mv=%0d",
						$realtime, want.level_percent, want.low_battery, want.average_ready,
						want.battery_millivolts, got.level_percent, got.low_battery,
						got.average_ready, got.battery_millivolts);
			end
		end
	endtask

	task automatic send_sample(input logic [ADC_W-1:0] sample, input bit last);
		repeat (send_gap) @(posedge clk);
		in_valid <= 1'b1;
		adc_sample <= sample;
		do @(posedge clk); while (!in_ready);
		predict_reading(sample);
		send_gap = send_fast ? 0 : $urandom_range(0, 14);
		// after the last item of a run, in_valid drops before the next raise
		if (last && send_gap == 0)
			send_gap = 1;
		if (last || send_gap != 0)
			in_valid <= 1'b0;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_VOLTAGE_SCALE)
			scale_mirror = data[SCALE_W-1:0];
		else if (idx == REG_LOW_WARNING)
			warn_mirror = data[PCT_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// first seven readings come before the ring wraps, the eighth is above the curve
	task automatic test_ring_fill();
		send_sample(ADC_W'(0), 1'b0);
		for (int i = 0; i < RING_SLOTS - 1; i++)
			send_sample('1, i == RING_SLOTS - 2);
	endtask

	// draining the ring steps the voltage down from above the curve to the bottom
	task automatic test_curve_ends();
		for (int i = 0; i < RING_SLOTS; i++)
			send_sample(ADC_W'(0), i == RING_SLOTS - 1);
	endtask

	task automatic test_registers();
		wait_idle();
		// all data bits set: threshold 127, above any percent
		cfg_write(REG_LOW_WARNING, '1);
		send_sample(ADC_W'(600), 1'b0);
		send_sample('1, 1'b1);
		wait_idle();
		cfg_write(REG_VOLTAGE_SCALE, '0);
		send_sample('1, 1'b1);
		wait_idle();
		cfg_write(REG_VOLTAGE_SCALE, '1);
		cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_write(REG_LOW_WARNING, CFG_DATA_W'(100));
		send_sample('1, 1'b0);
		send_sample(ADC_W'(512), 1'b1);
		wait_idle();
		cfg_write(REG_VOLTAGE_SCALE, SCALE_RESET);
		cfg_write(REG_LOW_WARNING, CFG_DATA_W'(WARN_RESET));
	endtask

	// samples hover around a drifting level aimed into the curve, with some noise
	task automatic test_random_sweep();
		logic [SCALE_W-1:0]    scale_pick;
		logic [PCT_W-1:0]      warn_pick;
		logic [CFG_DATA_W-1:0] warn_data;
		int                    center;
		int                    value;
		int                    count;
		for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0:       scale_pick = SCALE_RESET;
				1:       scale_pick = '0;
				2:       scale_pick = '1;
				3:       scale_pick = SCALE_W'($urandom);
				default: scale_pick = SCALE_W'($urandom_range(300000, 600000));
			endcase
			case ($urandom_range(0, 4))
				0:       warn_pick = '0;
				1:       warn_pick = PCT_W'(100);
				2:       warn_pick = '1;
				default: warn_pick = PCT_W'($urandom_range(0, 100));
			endcase
			warn_data = CFG_DATA_W'($urandom);
			warn_data[PCT_W-1:0] = warn_pick;
			cfg_write(REG_VOLTAGE_SCALE, CFG_DATA_W'(scale_pick));
			cfg_write(REG_LOW_WARNING, warn_data);
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
			send_fast = ($urandom_range(0, 3) == 0);
			if (scale_pick == '0)
				center = $urandom_range(0, 1023);
			else
				center = int'($urandom_range(2400, 4400)) * 65536 / int'(scale_pick);
			if (center > 1023)
				center = 1023;
			count = $urandom_range(40, 80);
			for (int i = 0; i < count; i++) begin
				center = center + int'($urandom_range(0, 6)) - 3;
				if (center < 0)
					center = 0;
				if (center > 1023)
					center = 1023;
				case ($urandom_range(0, 9))
					0:       value = $urandom_range(0, 1023);
					1:       value = ($urandom_range(0, 1) == 1) ? 1023 : 0;
					default: value = center + int'($urandom_range(0, 80)) - 40;
				endcase
				if (value < 0)
					value = 0;
				if (value > 1023)
					value = 1023;
				send_sample(ADC_W'(value), i == count - 1);
			end
		end
		send_fast = 1'b0;
	endtask

	// result side: stall counts down only while a reading is on offer
	initial begin : reading_sink
		int stall;
		bit sink_fast;
		stall = 0;
		sink_fast = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_reading();
				if ($urandom_range(0, 39) == 0)
					sink_fast = !sink_fast;
				stall = sink_fast ? 0 : $urandom_range(0, 14);
			end else if (out_valid && stall != 0) begin
				stall--;
			end
			out_ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL battery_level_gauge");
				$finish;
			end
		end
	end

	initial begin
		foreach (ring_mirror[k])
			ring_mirror[k] = '0;
		ring_wr_ptr = '0;
		ring_full = 1'b0;
		scale_mirror = SCALE_RESET;
		warn_mirror = WARN_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ring_fill();
		test_curve_ends();
		test_registers();
		test_random_sweep();
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS battery_level_gauge");
		else
			$display("FAIL battery_level_gauge");
		$finish;
	end

endmodule
